// ===== rtl/core/rtp_path_jitter_spike_tracker_core_assert.svh =====
// assertion macros for the rtp path jitter and spike tracker
// used by the checker module, no other dependencies
`ifndef RTP_PATH_JITTER_SPIKE_TRACKER_CORE_ASSERT_SVH
`define RTP_PATH_JITTER_SPIKE_TRACKER_CORE_ASSERT_SVH

// assertion that is off while reset is high
`define RPJST_ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rpjst assertion failed");

// assertion that also holds through reset
`define RPJST_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("rpjst assertion failed");

`endif

// ===== rtl/core/rpjst_pkg.sv =====
// shared types, widths and constants for the rtp path jitter and spike tracker
// no dependencies
`default_nettype none

package rpjst_pkg;

   localparam int SEQ_W     = 16;
   localparam int TS_W      = 32;
   localparam int DELAY_W   = 40;
   localparam int LEN_W     = 16;
   localparam int TOTAL_W   = 32;
   localparam int JIT_W     = 32;
   localparam int WRAP_W    = 16;
   localparam int SLOPE_W   = 42;
   localparam int CSR_IDX_W = 2;

   localparam int JITTER_SHIFT = 4;
   localparam int SLOPE_SHIFT  = 3;

   localparam logic [SEQ_W-1:0]   SEQ_WRAP_HIGH = 16'd65472;
   localparam logic [SEQ_W-1:0]   SEQ_WRAP_LOW  = 16'd128;
   localparam logic [DELAY_W-1:0] SPIKE_DELAY_THR_RESET = 40'd375000000;
   localparam logic [DELAY_W-1:0] SPIKE_SLOPE_THR_RESET = 40'd20000000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPIKE_DELAY_THR = 2'd0,
      CSR_SPIKE_SLOPE_THR = 2'd1
   } csr_index_type;

   typedef enum logic {
      OP_PACKET       = 1'b0,
      OP_DELAY_SAMPLE = 1'b1
   } op_type;

   typedef struct packed {
      logic               op;
      logic [SEQ_W-1:0]   seq_num;
      logic [TS_W-1:0]    rtp_time;
      logic [DELAY_W-1:0] delay_ns;
      logic [LEN_W-1:0]   payload_len;
   } req_item_type;

   function automatic logic [DELAY_W-1:0] abs_diff(input logic [DELAY_W-1:0] a,
                                                   input logic [DELAY_W-1:0] b);
      abs_diff = (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rtp_path_jitter_spike_tracker_core.sv =====
// top level of the rtp path jitter and delay spike tracker
// depends on rpjst_pkg
`default_nettype none

// One item per clock while the result side is ready. An accepted item is held
// in the input register; the single update stage then writes the path state,
// and those registers are the result. A stalled result holds while one further
// item waits in the input register.
// Each result reports the state after its item. A packet with zero delay is
// reported with accepted low and changes nothing; a bare delay sample only
// drives the spike detector. Threshold registers take writes every cycle and
// are meant to be changed while no item is in flight.
module rtp_path_jitter_spike_tracker_core (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_op,
   input  wire logic [rpjst_pkg::SEQ_W-1:0]       req_seq_num,
   input  wire logic [rpjst_pkg::TS_W-1:0]        req_rtp_time,
   input  wire logic [rpjst_pkg::DELAY_W-1:0]     req_delay_ns,
   input  wire logic [rpjst_pkg::LEN_W-1:0]       req_payload_len,

   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_accepted,
   output logic [rpjst_pkg::SEQ_W-1:0]            rsp_highest_seq_out,
   output logic [rpjst_pkg::WRAP_W-1:0]           rsp_cycle_count_out,
   output logic [rpjst_pkg::JIT_W-1:0]            rsp_jitter_out,
   output logic [rpjst_pkg::TOTAL_W-1:0]          rsp_packets_out,
   output logic [rpjst_pkg::TOTAL_W-1:0]          rsp_bytes_out,
   output logic                                   rsp_spike_flag,
   output logic [rpjst_pkg::TS_W-1:0]             rsp_newest_rtp_time,

   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [rpjst_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [rpjst_pkg::DELAY_W-1:0]     csr_wdata
);
   import rpjst_pkg::*;

   logic                 s1_valid_ff;
   req_item_type         s1_item_ff;
   logic                 advance;

   logic                 rsp_valid_ff;
   logic                 accepted_ff;
   logic                 accepted_in;

   logic [DELAY_W-1:0]   delay_thr_ff;
   logic [DELAY_W-1:0]   slope_thr_ff;

   logic                 started_ff,    started_in;
   logic [SEQ_W-1:0]     last_seq_ff,   last_seq_in;
   logic [WRAP_W-1:0]    wrap_ff,       wrap_in;
   logic [JIT_W-1:0]     jitter_ff,     jitter_in;
   logic [DELAY_W-1:0]   prev_delay_ff, prev_delay_in;
   logic [TOTAL_W-1:0]   packets_ff,    packets_in;
   logic [TOTAL_W-1:0]   bytes_ff,      bytes_in;
   logic [TS_W-1:0]      stamp_ff,      stamp_in;
   logic                 spike_ff,      spike_in;
   logic [SLOPE_W-1:0]   slope_ff,      slope_in;
   logic [DELAY_W-1:0]   hist1_ff,      hist1_in;
   logic [DELAY_W-1:0]   hist2_ff,      hist2_in;

   logic                 delay_zero;
   logic                 feed;
   logic                 pkt_update;
   logic                 pkt_first;
   logic [DELAY_W-1:0]   jump;
   logic [DELAY_W-1:0]   jump2;
   logic [DELAY_W:0]     jump_sum;
   logic [SLOPE_W-1:0]   slope_calc;
   logic [DELAY_W-1:0]   skew;
   logic [DELAY_W-1:0]   jit_ext;
   logic [DELAY_W-1:0]   jit_calc;
   logic [TS_W-1:0]      stamp_dist;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign csr_ready = 1'b1;

   // detector arithmetic
   assign jump       = abs_diff(s1_item_ff.delay_ns, hist1_ff);
   assign jump2      = abs_diff(s1_item_ff.delay_ns, hist2_ff);
   assign jump_sum   = {1'b0, jump} + {1'b0, jump2};
   assign slope_calc = {1'b0, slope_ff[SLOPE_W-1:1]}
                     + SLOPE_W'(jump_sum >> SLOPE_SHIFT);

   // jitter arithmetic
   assign skew     = abs_diff(prev_delay_ff, s1_item_ff.delay_ns);
   assign jit_ext  = DELAY_W'(jitter_ff);
   assign jit_calc = (skew >= jit_ext) ? (jit_ext + ((skew - jit_ext) >> JITTER_SHIFT))
                                       : (jit_ext - ((jit_ext - skew) >> JITTER_SHIFT));

   assign stamp_dist = s1_item_ff.rtp_time - stamp_ff;

   assign delay_zero = (s1_item_ff.delay_ns == '0);
   assign feed       = (s1_item_ff.op == OP_DELAY_SAMPLE) || !delay_zero;
   assign pkt_first  = (s1_item_ff.op == OP_PACKET) && !delay_zero && !started_ff;
   assign pkt_update = (s1_item_ff.op == OP_PACKET) && !delay_zero && started_ff;

   always_comb begin
      accepted_in   = feed;
      started_in    = started_ff;
      last_seq_in   = last_seq_ff;
      wrap_in       = wrap_ff;
      jitter_in     = jitter_ff;
      prev_delay_in = prev_delay_ff;
      packets_in    = packets_ff;
      bytes_in      = bytes_ff;
      stamp_in      = stamp_ff;
      spike_in      = spike_ff;
      slope_in      = slope_ff;
      hist1_in      = hist1_ff;
      hist2_in      = hist2_ff;

      if (feed) begin
         if (jump > delay_thr_ff) begin
            spike_in = 1'b1;
            slope_in = '0;
         end else if (spike_ff) begin
            slope_in = slope_calc;
            spike_in = !(slope_calc < SLOPE_W'(slope_thr_ff));
         end
         hist2_in = hist1_ff;
         hist1_in = s1_item_ff.delay_ns;
      end

      if (pkt_first) begin
         started_in    = 1'b1;
         last_seq_in   = s1_item_ff.seq_num;
         packets_in    = TOTAL_W'(1);
         bytes_in      = TOTAL_W'(s1_item_ff.payload_len);
         stamp_in      = s1_item_ff.rtp_time;
         prev_delay_in = s1_item_ff.delay_ns;
      end

      if (pkt_update) begin
         jitter_in     = jit_calc[JIT_W-1:0];
         prev_delay_in = s1_item_ff.delay_ns;
         packets_in    = packets_ff + TOTAL_W'(1);
         bytes_in      = bytes_ff + TOTAL_W'(s1_item_ff.payload_len);
         if ((stamp_dist != '0) && !stamp_dist[TS_W-1]) begin
            stamp_in = s1_item_ff.rtp_time;
         end
         if ((last_seq_ff > SEQ_WRAP_HIGH) && (s1_item_ff.seq_num < SEQ_WRAP_LOW)) begin
            wrap_in = wrap_ff + WRAP_W'(1);
         end
         last_seq_in = s1_item_ff.seq_num;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         s1_item_ff.op          <= req_op;
         s1_item_ff.seq_num     <= req_seq_num;
         s1_item_ff.rtp_time    <= req_rtp_time;
         s1_item_ff.delay_ns    <= req_delay_ns;
         s1_item_ff.payload_len <= req_payload_len;
      end
   end

   // path state, which is also the result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         accepted_ff   <= 1'b0;
         started_ff    <= 1'b0;
         last_seq_ff   <= '0;
         wrap_ff       <= '0;
         jitter_ff     <= '0;
         prev_delay_ff <= '0;
         packets_ff    <= '0;
         bytes_ff      <= '0;
         stamp_ff      <= '0;
         spike_ff      <= 1'b0;
         slope_ff      <= '0;
         hist1_ff      <= '0;
         hist2_ff      <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            accepted_ff   <= accepted_in;
            started_ff    <= started_in;
            last_seq_ff   <= last_seq_in;
            wrap_ff       <= wrap_in;
            jitter_ff     <= jitter_in;
            prev_delay_ff <= prev_delay_in;
            packets_ff    <= packets_in;
            bytes_ff      <= bytes_in;
            stamp_ff      <= stamp_in;
            spike_ff      <= spike_in;
            slope_ff      <= slope_in;
            hist1_ff      <= hist1_in;
            hist2_ff      <= hist2_in;
         end
      end
   end

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_thr_ff <= SPIKE_DELAY_THR_RESET;
         slope_thr_ff <= SPIKE_SLOPE_THR_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SPIKE_DELAY_THR: begin
               delay_thr_ff <= csr_wdata;
            end
            CSR_SPIKE_SLOPE_THR: begin
               slope_thr_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = accepted_ff;
   assign rsp_highest_seq_out = last_seq_ff;
   assign rsp_cycle_count_out = wrap_ff;
   assign rsp_jitter_out      = jitter_ff;
   assign rsp_packets_out     = packets_ff;
   assign rsp_bytes_out       = bytes_ff;
   assign rsp_spike_flag      = spike_ff;
   assign rsp_newest_rtp_time = stamp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/rpjst_chk.sv =====
// handshake checker for the rtp path jitter and spike tracker, with its bind
// depends on rtp_path_jitter_spike_tracker_core_assert.svh
`default_nettype none

`include "rtp_path_jitter_spike_tracker_core_assert.svh"

module rpjst_chk (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   req_valid,
   input  wire logic   req_ready,
   input  wire logic   rsp_valid,
   input  wire logic   rsp_ready
);
   logic rsp_stall;
   logic req_take;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign req_take  = req_valid && req_ready;

   // a stalled result stays valid
   `RPJST_ASSERT_RST(a_rsp_hold, clock, reset, rsp_stall |=> rsp_valid)

   // reset empties both stages
   `RPJST_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && req_ready)

   // one item taken behind a stalled result fills the input stage
   `RPJST_ASSERT_RST(a_one_behind, clock, reset, (rsp_stall && req_take) ##1 !rsp_ready |-> !req_ready)

endmodule

bind rtp_path_jitter_spike_tracker_core rpjst_chk u_rpjst_chk (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// testbench for the rtp path jitter and delay spike tracker core
// predicts every result from its own copy of the path state and checks it field by field
// depends on rpjst_pkg and rtp_path_jitter_spike_tracker_core
module tb;
   import rpjst_pkg::*;

   localparam int QUIET_LIMIT    = 2000;
   localparam int RESULT_LATENCY = 4;
   localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

   typedef struct packed {
      logic               accepted;
      logic [SEQ_W-1:0]   seq_seen;
      logic [WRAP_W-1:0]  cycle_count;
      logic [JIT_W-1:0]   jitter;
      logic [TOTAL_W-1:0] packets;
      logic [TOTAL_W-1:0] byte_total;
      logic               spike;
      logic [TS_W-1:0]    newest_ts;
   } path_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_valid = 1'b0;
   logic          req_ready;
   req_item_type  req_item = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_accepted;
   logic [SEQ_W-1:0]      rsp_highest_seq_out;
   logic [WRAP_W-1:0]     rsp_cycle_count_out;
   logic [JIT_W-1:0]      rsp_jitter_out;
   logic [TOTAL_W-1:0]    rsp_packets_out;
   logic [TOTAL_W-1:0]    rsp_bytes_out;
   logic                  rsp_spike_flag;
   logic [TS_W-1:0]       rsp_newest_rtp_time;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_SPIKE_DELAY_THR;
   logic [DELAY_W-1:0]    csr_wdata = '0;

   int req_idle_pct  = 25;
   int rsp_idle_pct  = 25;
   int hold_off_left = 0;
   int error_count   = 0;
   int result_count  = 0;
   int quiet_cycles  = 0;

   path_status_type pending_status_q[$];

   // predicted path state
   logic [DELAY_W-1:0] spike_jump_thr = SPIKE_DELAY_THR_RESET;
   logic [DELAY_W-1:0] spike_exit_thr = SPIKE_SLOPE_THR_RESET;
   logic               trk_started    = 1'b0;
   logic [SEQ_W-1:0]   trk_last_seq   = '0;
   logic [WRAP_W-1:0]  trk_wraps      = '0;
   logic [JIT_W-1:0]   trk_jitter     = '0;
   logic [DELAY_W-1:0] trk_prev_delay = '0;
   logic [TOTAL_W-1:0] trk_packets    = '0;
   logic [TOTAL_W-1:0] trk_bytes      = '0;
   logic [TS_W-1:0]    trk_newest_ts  = '0;
   logic               trk_in_spike   = 1'b0;
   logic [SLOPE_W-1:0] trk_slope      = '0;
   logic [DELAY_W-1:0] trk_hist1      = '0;
   logic [DELAY_W-1:0] trk_hist2      = '0;

   // random stream cursors
   logic [SEQ_W-1:0]   seq_cursor  = '0;
   logic [TS_W-1:0]    ts_cursor   = '0;
   logic [DELAY_W-1:0] delay_base  = 40'd20000000;

   rtp_path_jitter_spike_tracker_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_item.op),
      .req_seq_num         (req_item.seq_num),
      .req_rtp_time        (req_item.rtp_time),
      .req_delay_ns        (req_item.delay_ns),
      .req_payload_len     (req_item.payload_len),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_accepted        (rsp_accepted),
      .rsp_highest_seq_out (rsp_highest_seq_out),
      .rsp_cycle_count_out (rsp_cycle_count_out),
      .rsp_jitter_out      (rsp_jitter_out),
      .rsp_packets_out     (rsp_packets_out),
      .rsp_bytes_out       (rsp_bytes_out),
      .rsp_spike_flag      (rsp_spike_flag),
      .rsp_newest_rtp_time (rsp_newest_rtp_time),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [DELAY_W-1:0] delay_gap(input logic [DELAY_W-1:0] a,
                                                    input logic [DELAY_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

   function automatic void feed_spike_detector(input logic [DELAY_W-1:0] d);
      logic [DELAY_W-1:0] jump;
      logic [DELAY_W:0]   sum;
      jump = delay_gap(d, trk_hist1);
      if (jump > spike_jump_thr) begin
         trk_in_spike = 1'b1;
         trk_slope = '0;
      end else if (trk_in_spike) begin
         sum = {1'b0, jump} + {1'b0, delay_gap(d, trk_hist2)};
         trk_slope = (trk_slope >> 1) + SLOPE_W'(sum >> SLOPE_SHIFT);
         if (trk_slope < {2'b00, spike_exit_thr})
            trk_in_spike = 1'b0;
      end
      trk_hist2 = trk_hist1;
      trk_hist1 = d;
   endfunction

   function automatic path_status_type track_item(input req_item_type it);
      logic [DELAY_W-1:0] skew;
      logic [SLOPE_W-1:0] skew_x;
      logic [SLOPE_W-1:0] jit;
      logic [TS_W-1:0]    ts_gap;
      path_status_type    st;
      st.accepted = 1'b1;
      if (it.op == OP_DELAY_SAMPLE) begin
         feed_spike_detector(it.delay_ns);
      end else if (it.delay_ns == '0) begin
         st.accepted = 1'b0;
      end else if (!trk_started) begin
         trk_last_seq   = it.seq_num;
         trk_packets    = 32'd1;
         trk_bytes      = TOTAL_W'(it.payload_len);
         trk_newest_ts  = it.rtp_time;
         trk_prev_delay = it.delay_ns;
         feed_spike_detector(it.delay_ns);
         trk_started    = 1'b1;
      end else begin
         skew   = delay_gap(trk_prev_delay, it.delay_ns);
         skew_x = SLOPE_W'(skew);
         jit    = SLOPE_W'(trk_jitter);
         if (skew_x >= jit)
            jit = jit + ((skew_x - jit) >> JITTER_SHIFT);
         else
            jit = jit - ((jit - skew_x) >> JITTER_SHIFT);
         trk_jitter     = jit[JIT_W-1:0];
         trk_prev_delay = it.delay_ns;
         trk_packets    = trk_packets + 32'd1;
         trk_bytes      = trk_bytes + TOTAL_W'(it.payload_len);
         ts_gap = it.rtp_time - trk_newest_ts;
         if (ts_gap != '0 && !ts_gap[TS_W-1])
            trk_newest_ts = it.rtp_time;
         feed_spike_detector(it.delay_ns);
         if (trk_last_seq > SEQ_WRAP_HIGH && it.seq_num < SEQ_WRAP_LOW)
            trk_wraps = trk_wraps + 16'd1;
         trk_last_seq = it.seq_num;
      end
      st.seq_seen    = trk_last_seq;
      st.cycle_count = trk_wraps;
      st.jitter      = trk_jitter;
      st.packets     = trk_packets;
      st.byte_total  = trk_bytes;
      st.spike       = trk_in_spike;
      st.newest_ts   = trk_newest_ts;
      return st;
   endfunction

   function automatic req_item_type make_item(input op_type op, input logic [SEQ_W-1:0] seq,
                                              input logic [TS_W-1:0] ts,
                                              input logic [DELAY_W-1:0] d,
                                              input logic [LEN_W-1:0] len);
      req_item_type it;
      it.op          = op;
      it.seq_num     = seq;
      it.rtp_time    = ts;
      it.delay_ns    = d;
      it.payload_len = len;
      return it;
   endfunction

   // mostly in-order packets around a slowly moving delay, with reorders, jumps and noise
   function automatic req_item_type random_packet();
      int unsigned        pick;
      op_type             op;
      logic [DELAY_W-1:0] d;
      pick = $urandom_range(99);
      op = (pick < 10) ? OP_DELAY_SAMPLE : OP_PACKET;
      pick = $urandom_range(99);
      if (pick < 4)
         seq_cursor = SEQ_W'($urandom_range(65535, 65473));
      else if (pick < 8)
         seq_cursor = SEQ_W'($urandom);
      else if (pick < 12)
         seq_cursor = seq_cursor - SEQ_W'($urandom_range(3, 1));
      else
         seq_cursor = seq_cursor + 16'd1;
      pick = $urandom_range(99);
      if (pick < 5)
         ts_cursor = TS_W'($urandom);
      else if (pick < 7)
         ts_cursor = ts_cursor + 32'h8000_0000;
      else if (pick < 10)
         ts_cursor = ts_cursor - TS_W'($urandom_range(3000));
      else
         ts_cursor = ts_cursor + TS_W'($urandom_range(3000));
      if ($urandom_range(99) < 4)
         delay_base = DELAY_W'($urandom_range(1500000000, 1000000));
      pick = $urandom_range(99);
      if (pick < 5)
         d = '0;
      else if (pick < 10)
         d = DELAY_W'({$urandom, $urandom});
      else
         d = delay_base + DELAY_W'($urandom_range(2000000));
      return make_item(op, seq_cursor, ts_cursor, d, LEN_W'($urandom));
   endfunction

   task automatic report_mismatch(input string what);
      $display("error: result %0d: %s", result_count, what);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin
      path_status_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SPIKE_DELAY_THR)
               spike_jump_thr = csr_wdata;
            else if (csr_index == CSR_SPIKE_SLOPE_THR)
               spike_exit_thr = csr_wdata;
         end
         if (req_valid && req_ready)
            pending_status_q.push_back(track_item(req_item));
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (pending_status_q.size() == 0) begin
               report_mismatch("result with no item pending");
            end else begin
               want = pending_status_q.pop_front();
               check_field("accepted", 64'(rsp_accepted), 64'(want.accepted));
               check_field("last seq", 64'(rsp_highest_seq_out), 64'(want.seq_seen));
               check_field("cycle_count", 64'(rsp_cycle_count_out), 64'(want.cycle_count));
               check_field("jitter", 64'(rsp_jitter_out), 64'(want.jitter));
               check_field("packets", 64'(rsp_packets_out), 64'(want.packets));
               check_field("bytes", 64'(rsp_bytes_out), 64'(want.byte_total));
               check_field("spike_flag", 64'(rsp_spike_flag), 64'(want.spike));
               check_field("newest_rtp_time", 64'(rsp_newest_rtp_time), 64'(want.newest_ts));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // result side, with an optional long hold-off
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready = 1'b0;
         hold_off_left--;
      end else begin
         rsp_ready = ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_item(input req_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_item  = it;
      req_valid = 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   task automatic send_random(input int count);
      repeat (count)
         send_item(random_packet());
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_status_q.size() != 0)
         @(negedge clock);
      repeat (RESULT_LATENCY)
         @(negedge clock);
   endtask

   task automatic write_threshold(input csr_index_type idx, input logic [DELAY_W-1:0] value);
      @(negedge clock);
      csr_index = idx;
      csr_wdata = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_thresholds(input logic [DELAY_W-1:0] jump_thr,
                                 input logic [DELAY_W-1:0] exit_thr);
      wait_all_results();
      write_threshold(CSR_SPIKE_DELAY_THR, jump_thr);
      write_threshold(CSR_SPIKE_SLOPE_THR, exit_thr);
   endtask

   task automatic set_idle(input int req_pct, input int rsp_pct);
      @(negedge clock);
      req_valid    = 1'b0;
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
   endtask

   task automatic test_directed_cases();
      // rejects and bare samples before the first packet
      send_item(make_item(OP_PACKET, 16'd100, 32'd5, 40'd0, 16'd10));
      send_item(make_item(OP_DELAY_SAMPLE, 16'd0, 32'd0, 40'd0, 16'd0));
      send_item(make_item(OP_PACKET, 16'd65500, 32'hFFFF_FFF0, 40'd1000, 16'hFFFF));
      // wrap, timestamp across zero, spike entry then decay
      send_item(make_item(OP_PACKET, 16'd3, 32'h0000_0010, 40'd500000000, 16'd0));
      send_item(make_item(OP_PACKET, 16'd4, 32'h8000_0010, 40'd500000100, 16'd1));
      send_item(make_item(OP_PACKET, 16'd5, 32'h0000_000F, 40'd500000000, 16'd2));
      send_item(make_item(OP_PACKET, 16'd6, 32'h0000_0010, 40'd500000000, 16'd3));
      send_item(make_item(OP_PACKET, 16'd7, 32'h8000_000F, 40'd500000000, 16'd4));
      // largest delays, jitter overflow and decrement
      send_item(make_item(OP_PACKET, 16'd8, 32'h8000_0010, DELAY_MAX, 16'hFFFF));
      send_item(make_item(OP_PACKET, 16'd9, 32'h8000_0011, DELAY_MAX, 16'd5));
      send_item(make_item(OP_PACKET, 16'd10, 32'h8000_0012, 40'd1, 16'd6));
      send_item(make_item(OP_PACKET, 16'd11, 32'h8000_0013, 40'd0, 16'd7));
      send_item(make_item(OP_DELAY_SAMPLE, 16'hFFFF, 32'hFFFF_FFFF, DELAY_MAX, 16'hFFFF));
      send_item(make_item(OP_DELAY_SAMPLE, 16'd12, 32'd0, 40'd0, 16'd0));
      // sequence wrap boundaries
      send_item(make_item(OP_PACKET, 16'd65535, 32'h8000_0014, 40'd2000, 16'd8));
      send_item(make_item(OP_PACKET, 16'd127, 32'h8000_0015, 40'd2100, 16'd9));
      send_item(make_item(OP_PACKET, 16'd128, 32'h8000_0016, 40'd2200, 16'd10));
      send_item(make_item(OP_PACKET, 16'd65472, 32'h8000_0017, 40'd2300, 16'd11));
      send_item(make_item(OP_PACKET, 16'd0, 32'h8000_0018, 40'd2400, 16'd12));
      send_item(make_item(OP_PACKET, 16'd65473, 32'h8000_0019, 40'd2500, 16'd13));
      send_item(make_item(OP_PACKET, 16'd127, 32'h8000_001A, 40'd2600, 16'd14));
      send_item(make_item(OP_PACKET, 16'd65535, 32'hFFFF_FFFF, 40'd1, 16'd0));
   endtask

   task automatic test_threshold_extremes();
      set_thresholds('0, '0);
      send_random(50);
      set_thresholds(DELAY_MAX, DELAY_MAX);
      send_random(50);
      set_thresholds('0, DELAY_MAX);
      send_random(50);
      set_thresholds(DELAY_MAX, '0);
      send_random(50);
      set_thresholds(SPIKE_DELAY_THR_RESET, SPIKE_SLOPE_THR_RESET);
   endtask

   task automatic test_result_backpressure();
      wait_all_results();
      set_idle(0, 25);
      hold_off_left = 80;
      send_random(40);
      set_idle(25, 25);
   endtask

   task automatic test_drain_pause();
      send_random(30);
      wait_all_results();
      send_random(30);
   endtask

   task automatic test_streaming_no_idle();
      set_idle(0, 0);
      send_random(300);
      set_idle(25, 25);
   endtask

   task automatic test_random_traffic();
      repeat (4) begin
         set_thresholds(DELAY_W'($urandom_range(800000000, 1000000)),
                        DELAY_W'($urandom_range(50000000)));
         send_random(250);
      end
      set_thresholds(DELAY_W'({$urandom, $urandom}), DELAY_W'({$urandom, $urandom}));
      send_random(60);
      set_thresholds(SPIKE_DELAY_THR_RESET, SPIKE_SLOPE_THR_RESET);
      send_random(70);
   endtask

   initial begin
      repeat (10)
         @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_cases();
      test_threshold_extremes();
      test_result_backpressure();
      test_drain_pause();
      test_streaming_no_idle();
      test_random_traffic();
      wait_all_results();
      repeat (8)
         @(posedge clock);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/rpjst_pkg.sv
rtl/core/rtp_path_jitter_spike_tracker_core.sv
rtl/core/rpjst_chk.sv
sim/tb.sv
